// ----- design/population_odometer_offset_unit_defines.svh -----
// assertion macros shared by the odometer offset unit
`ifndef POPULATION_ODOMETER_OFFSET_UNIT_DEFINES_SVH
`define POPULATION_ODOMETER_OFFSET_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// clocked check, switched off while reset is asserted
`define PODO_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define PODO_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PODO_ASSERT(label, clk, rst_n, prop, msg)
`define PODO_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- design/podo_pkg.sv -----
// shared types and constants of the odometer offset unit
package podo_pkg;

	localparam int OFFSET_W     = 16;
	localparam int STRIDE_W     = 13;
	localparam int REMOVED_W    = 3;
	localparam int FIELD_W      = 4;
	localparam int OUT_CLASSES  = 4;
	localparam int REG_COUNT    = 8;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;
	localparam int RST_RADIX_LOG = 4;

	typedef logic [FIELD_W-1:0]   field_t;
	typedef logic [OFFSET_W-1:0]  offset_t;
	typedef logic [STRIDE_W-1:0]  stride_t;
	typedef logic [REMOVED_W-1:0] removed_t;

	localparam field_t RST_MAX = 4'd15;

	typedef enum logic [2:0] {
		REG_MAX_1   = 3'd0,
		REG_MAX_2   = 3'd1,
		REG_MAX_3   = 3'd2,
		REG_MAX_4   = 3'd3,
		REG_LIMIT_1 = 3'd4,
		REG_LIMIT_2 = 3'd5,
		REG_LIMIT_3 = 3'd6,
		REG_LIMIT_4 = 3'd7
	} reg_idx_t;

	// handoff from the step pipeline to the result emitter
	typedef struct packed {
		logic valid;
		logic wrapped;
	} item_ctl_t;

endpackage

// ----- design/podo_step_if.sv -----
// input word channel: one restart bit per word
interface podo_step_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// ----- design/podo_result_if.sv -----
// result word channel: offset, removed class, flags and counts
interface podo_result_if;
	import podo_pkg::*;

	logic     valid;
	logic     ready;
	offset_t  linear_offset;
	removed_t removed_class;
	logic     wrapped;
	logic     last_of_run;
	field_t   count_class_1;
	field_t   count_class_2;
	field_t   count_class_3;
	field_t   count_class_4;

	modport source (output valid, output linear_offset, output removed_class,
		output wrapped, output last_of_run, output count_class_1,
		output count_class_2, output count_class_3, output count_class_4,
		input ready);
	modport sink (input valid, input linear_offset, input removed_class,
		input wrapped, input last_of_run, input count_class_1,
		input count_class_2, input count_class_3, input count_class_4,
		output ready);
endinterface

// ----- design/podo_cfg.sv -----
// register file, stride derivation and effective limits
module podo_cfg #(
	parameter int CLASSES    = 4,
	parameter int COUNT_BITS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [podo_pkg::ADDR_W-1:0] paddr,
	input  logic [podo_pkg::DATA_W-1:0] pwdata,
	output logic [podo_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic                        busy,
	output podo_pkg::stride_t           stride [CLASSES],
	output logic [COUNT_BITS-1:0]       eff_limit [CLASSES]
);
	import podo_pkg::*;

	localparam int SETTLE_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int CMAX     = (1 << COUNT_BITS) - 1;

	field_t              reg_q [REG_COUNT];
	logic [SETTLE_W-1:0] settle_q;
	stride_t             stride_q [CLASSES];
	reg_idx_t            idx;
	logic                wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign prdata = DATA_W'(reg_q[idx]);
	assign busy   = (settle_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) reg_q[i] <= RST_MAX;
		end else if (wr_en) begin
			reg_q[idx] <= pwdata[FIELD_W-1:0];
		end
	end

	// a new maximum ripples one class further left each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
		end else if (wr_en && idx < REG_LIMIT_1) begin
			settle_q <= SETTLE_W'(CLASSES - 1);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	for (genvar c = 0; c < CLASSES; c++) begin : g_class
		if (c == CLASSES - 1) begin : g_lsd
			assign stride_q[c] = STRIDE_W'(1);
		end else begin : g_upper
			logic [FIELD_W:0] radix;
			assign radix = {1'b0, reg_q[c+1]} + (FIELD_W+1)'(1);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stride_q[c] <= STRIDE_W'(32'd1 << (RST_RADIX_LOG * (CLASSES - 1 - c)));
				end else begin
					stride_q[c] <= STRIDE_W'(stride_q[c+1] * STRIDE_W'(radix));
				end
			end
		end

		field_t lim;
		assign lim = (reg_q[REG_LIMIT_1 + c] > reg_q[c]) ? reg_q[c] : reg_q[REG_LIMIT_1 + c];
		assign eff_limit[c] = (int'(lim) > CMAX) ? COUNT_BITS'(CMAX) : COUNT_BITS'(lim);
		assign stride[c] = stride_q[c];
	end

endmodule

// ----- design/podo_step.sv -----
// count register, odometer step and offset product stages
module podo_step #(
	parameter int CLASSES    = 4,
	parameter int COUNT_BITS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_restart,
	input  logic                    busy,
	input  logic [COUNT_BITS-1:0]   eff_limit [CLASSES],
	input  podo_pkg::stride_t       stride [CLASSES],
	input  logic                    em_free,
	output podo_pkg::item_ctl_t     ctl,
	output logic [COUNT_BITS-1:0]   cnt_out [CLASSES],
	output podo_pkg::offset_t       prod_out [CLASSES]
);
	import podo_pkg::*;

	logic [COUNT_BITS-1:0] cnt_q [CLASSES];
	logic [COUNT_BITS-1:0] nxt [CLASSES];
	logic                  wrap;
	logic                  accept, s1_adv, s2_adv;

	logic                  valid_s1, wrap_s1;
	logic [COUNT_BITS-1:0] cnt_s1 [CLASSES];
	logic                  valid_s2, wrap_s2;
	logic [COUNT_BITS-1:0] cnt_s2 [CLASSES];
	offset_t               prod_s2 [CLASSES];

	// carry ripples from the last class leftwards
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int c = CLASSES - 1; c >= 0; c--) begin
			nxt[c] = cnt_q[c];
			if (carry) begin
				if (cnt_q[c] < eff_limit[c]) begin
					nxt[c] = cnt_q[c] + COUNT_BITS'(1);
					carry  = 1'b0;
				end else begin
					nxt[c] = '0;
				end
			end
			if (in_restart) nxt[c] = '0;
		end
		wrap = carry & ~in_restart;
	end

	assign s2_adv   = ~valid_s2 | em_free;
	assign s1_adv   = ~valid_s1 | s2_adv;
	assign in_ready = ~busy & s1_adv;
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASSES; c++) cnt_q[c] <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) cnt_q <= nxt;
			if (s1_adv) valid_s1 <= accept;
			if (s2_adv) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1  <= nxt;
			wrap_s1 <= wrap;
		end
		if (s2_adv && valid_s1) begin
			for (int c = 0; c < CLASSES; c++) begin
				prod_s2[c] <= OFFSET_W'(cnt_s1[c]) * OFFSET_W'(stride[c]);
			end
			cnt_s2  <= cnt_s1;
			wrap_s2 <= wrap_s1;
		end
	end

	assign ctl.valid   = valid_s2;
	assign ctl.wrapped = wrap_s2;
	assign cnt_out     = cnt_s2;
	assign prod_out    = prod_s2;

endmodule

// ----- design/podo_emit.sv -----
// result register: sums the offset and steps through the removed classes
`include "population_odometer_offset_unit_defines.svh"

module podo_emit #(
	parameter int CLASSES    = 4,
	parameter int COUNT_BITS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  podo_pkg::item_ctl_t      ctl,
	input  logic [COUNT_BITS-1:0]    cnt_in [CLASSES],
	input  podo_pkg::offset_t        prod_in [CLASSES],
	input  podo_pkg::stride_t        stride [CLASSES],
	output logic                     em_free,
	output logic                     out_valid,
	input  logic                     out_ready,
	output podo_pkg::offset_t        linear_offset,
	output podo_pkg::removed_t       removed_class,
	output logic                     wrapped,
	output logic                     last_of_run,
	output podo_pkg::field_t         count_out [podo_pkg::OUT_CLASSES]
);
	import podo_pkg::*;

	localparam int SEL_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;

	logic                  em_v_q, em_first_q, em_wrap_q;
	logic [CLASSES-1:0]    em_pend_q, rest, nz;
	offset_t               em_off_q, sum;
	logic [COUNT_BITS-1:0] em_cnt_q [CLASSES];
	logic [SEL_W-1:0]      sel;
	logic                  fire;

	always_comb begin
		sum = '0;
		for (int c = 0; c < CLASSES; c++) begin
			sum   = sum + prod_in[c];
			nz[c] = (cnt_in[c] != '0);
		end
	end

	// lowest pending class goes out first
	always_comb begin
		logic found;
		found = 1'b0;
		sel   = '0;
		for (int c = 0; c < CLASSES; c++) begin
			if (!found && em_pend_q[c]) begin
				sel   = SEL_W'(c);
				found = 1'b1;
			end
		end
	end

	assign rest        = em_pend_q & (em_pend_q - CLASSES'(1));
	assign last_of_run = em_first_q ? (em_pend_q == '0) : (rest == '0);
	assign fire        = em_v_q & out_ready;
	assign em_free     = ~em_v_q | (fire & last_of_run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_q     <= 1'b0;
			em_first_q <= 1'b0;
			em_pend_q  <= '0;
		end else if (em_free) begin
			em_v_q     <= ctl.valid;
			em_first_q <= 1'b1;
			em_pend_q  <= ctl.valid ? nz : '0;
		end else if (fire) begin
			if (em_first_q) em_first_q <= 1'b0;
			else            em_pend_q  <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (em_free && ctl.valid) begin
			em_off_q  <= sum;
			em_wrap_q <= ctl.wrapped;
			em_cnt_q  <= cnt_in;
		end
	end

	assign out_valid     = em_v_q;
	assign wrapped       = em_wrap_q;
	assign linear_offset = em_first_q ? em_off_q : em_off_q - OFFSET_W'(stride[sel]);
	assign removed_class = em_first_q ? '0 : removed_t'(sel) + removed_t'(1);

	for (genvar k = 0; k < OUT_CLASSES; k++) begin : g_cnt
		if (k < CLASSES) begin : g_used
			assign count_out[k] = FIELD_W'(em_cnt_q[k]);
		end else begin : g_unused
			assign count_out[k] = '0;
		end
	end

	`PODO_ASSERT_ALWAYS(a_idle_no_pend, clk, !em_v_q |-> em_pend_q == '0, "pending classes while empty")
	`PODO_ASSERT(a_wrap_single, clk, arst_n, em_v_q && em_wrap_q |-> last_of_run && linear_offset == '0, "wrap word not single zero word")
	`PODO_ASSERT(a_run_continues, clk, arst_n, fire && !last_of_run |=> em_v_q, "run ended before its last word")
	`PODO_ASSERT(a_removed_range, clk, arst_n, em_v_q |-> removed_class <= removed_t'(CLASSES), "removed class out of range")

endmodule

// ----- design/population_odometer_offset_unit.sv -----
// top level of the population odometer offset unit
//
//  channel  dir  handshake      carries
//  -------  ---  -------------  ----------------------------------------------
//  step     in   valid/ready    restart bit: advance or return to zero vector
//  result   out  valid/ready    offset, removed class, wrap/last flags, counts
//  apb      in   psel/penable   eight 4-bit registers, maxima then limits
//
// an advance gives 1 + (classes with nonzero count) result words, a restart or
// wrap gives one; the result register sends one word a cycle while result is
// ready, and a new word is taken every cycle while the emitter keeps up. the
// first result word passes stage 1, stage 2 and the result register after the
// accepting edge. after a maximum is written, strides settle with step ready
// held low by busy. arst_n clears counts, registers to 15 and the pipeline;
// a stall on result holds the emitter and backs up through the two step
// pipeline stages.
module population_odometer_offset_unit #(
	parameter int CLASSES    = 4,
	parameter int COUNT_BITS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	podo_step_if.sink                   step,
	podo_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [podo_pkg::ADDR_W-1:0] paddr,
	input  logic [podo_pkg::DATA_W-1:0] pwdata,
	output logic [podo_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import podo_pkg::*;

	// configuration side
	logic                  busy;
	stride_t               stride [CLASSES];
	logic [COUNT_BITS-1:0] eff_limit [CLASSES];

	// step pipeline to emitter
	item_ctl_t             ctl;
	logic [COUNT_BITS-1:0] cnt [CLASSES];
	offset_t               prod [CLASSES];
	logic                  em_free;
	field_t                count_out [OUT_CLASSES];

	podo_cfg #(.CLASSES(CLASSES), .COUNT_BITS(COUNT_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.busy      (busy),
		.stride    (stride),
		.eff_limit (eff_limit)
	);

	// odometer advance happens at accept; products registered behind it
	podo_step #(.CLASSES(CLASSES), .COUNT_BITS(COUNT_BITS)) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (step.valid),
		.in_ready   (step.ready),
		.in_restart (step.restart),
		.busy       (busy),
		.eff_limit  (eff_limit),
		.stride     (stride),
		.em_free    (em_free),
		.ctl        (ctl),
		.cnt_out    (cnt),
		.prod_out   (prod)
	);

	// result register walks the run of offset words
	podo_emit #(.CLASSES(CLASSES), .COUNT_BITS(COUNT_BITS)) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cnt_in        (cnt),
		.prod_in       (prod),
		.stride        (stride),
		.em_free       (em_free),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.linear_offset (result.linear_offset),
		.removed_class (result.removed_class),
		.wrapped       (result.wrapped),
		.last_of_run   (result.last_of_run),
		.count_out     (count_out)
	);

	assign result.count_class_1 = count_out[0];
	assign result.count_class_2 = count_out[1];
	assign result.count_class_3 = count_out[2];
	assign result.count_class_4 = count_out[3];

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for the population odometer offset unit
`timescale 1ns / 1ps

module testbench;
	import podo_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 16;
	localparam int RANDOM_PHASES  = 7;
	localparam int PHASE_WORDS    = 25;
	localparam int CLOSING_WORDS  = 40;

	// one expected result word, counts[0] is class 1
	typedef struct packed {
		offset_t                     linear_offset;
		removed_t                    removed_class;
		logic                        wrapped;
		logic                        last_of_run;
		logic [3:0][FIELD_W-1:0]     counts;
	} odo_word_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	podo_step_if   stp_if ();
	podo_result_if res_if ();

	// shadow of the population and the class registers
	field_t pop_count [4];
	field_t class_max [4];
	field_t class_limit [4];

	odo_word_t pending_words [$];
	int        mismatch_count = 0;
	int        gap_pct = 0;      // chance in percent of an idle burst, both sides
	int        stall_left = 0;
	int        quiet_cycles = 0;

	population_odometer_offset_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (stp_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one printed line per mismatch, and a count for the final verdict
	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// result word carrying the current population
	function automatic odo_word_t make_word(input int unsigned offset,
			input int unsigned removed, input logic wrapped, input logic last);
		odo_word_t w;
		w.linear_offset = offset[OFFSET_W-1:0];
		w.removed_class = removed[REMOVED_W-1:0];
		w.wrapped       = wrapped;
		w.last_of_run   = last;
		for (int c = 0; c < 4; c++)
			w.counts[c] = pop_count[c];
		return w;
	endfunction

	// steps the shadow population and queues the words it should give
	function automatic void advance_odometer(input logic restart);
		int unsigned stride [4];
		int unsigned product;
		int unsigned offset;
		int unsigned lim;
		int          c;
		int          words;
		int          k;
		bit          advanced;
		// stride of a class: product of (max+1) over the classes to its right
		product = 1;
		for (c = 3; c >= 0; c--) begin
			stride[c] = product & 32'h1FFF;
			product = product * (class_max[c] + 1);
		end
		if (restart) begin
			for (c = 0; c < 4; c++)
				pop_count[c] = '0;
			pending_words.push_back(make_word(0, 0, 1'b0, 1'b1));
			return;
		end
		// least significant digit is class 4; a count at or above its limit carries
		advanced = 1'b0;
		for (c = 3; c >= 0 && !advanced; c--) begin
			lim = (class_limit[c] > class_max[c]) ? class_max[c] : class_limit[c];
			if (pop_count[c] < lim) begin
				pop_count[c] = pop_count[c] + 1'b1;
				advanced = 1'b1;
			end else begin
				pop_count[c] = '0;
			end
		end
		// every class carried: a lone flagged word at the zero vector
		if (!advanced) begin
			pending_words.push_back(make_word(0, 0, 1'b1, 1'b1));
			return;
		end
		offset = 0;
		words = 1;
		for (c = 0; c < 4; c++) begin
			offset += pop_count[c] * stride[c];
			if (pop_count[c] != 0)
				words++;
		end
		pending_words.push_back(make_word(offset, 0, 1'b0, words == 1));
		// then one word per occupied class, class 1 first, one customer removed
		k = 1;
		for (c = 0; c < 4; c++) begin
			if (pop_count[c] != 0) begin
				pending_words.push_back(make_word(offset - stride[c], c + 1, 1'b0,
					k == words - 1));
				k++;
			end
		end
	endfunction

	// apb write: setup, access, then an idle cycle so psel never drops and rises in one step
	task automatic apb_write_reg(input reg_idx_t idx, input field_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(DATA_W - FIELD_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= REG_MAX_4)
			class_max[int'(idx)] = value;
		else
			class_limit[int'(idx) - int'(REG_LIMIT_1)] = value;
		@(posedge clk);
	endtask

	// all eight registers, maxima first
	task automatic program_classes(input field_t m1, input field_t m2, input field_t m3,
			input field_t m4, input field_t l1, input field_t l2, input field_t l3,
			input field_t l4);
		apb_write_reg(REG_MAX_1, m1);
		apb_write_reg(REG_MAX_2, m2);
		apb_write_reg(REG_MAX_3, m3);
		apb_write_reg(REG_MAX_4, m4);
		apb_write_reg(REG_LIMIT_1, l1);
		apb_write_reg(REG_LIMIT_2, l2);
		apb_write_reg(REG_LIMIT_3, l3);
		apb_write_reg(REG_LIMIT_4, l4);
	endtask

	// one step word; valid stays high into the next word unless a gap is taken
	task automatic send_step(input logic restart);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			stp_if.valid <= 1'b0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
		stp_if.valid   <= 1'b1;
		stp_if.restart <= restart;
		@(posedge clk);
		while (!stp_if.ready) @(posedge clk);
		advance_odometer(restart);
	endtask

	// every step word gives at least one result, so an empty queue means idle
	task automatic wait_until_drained();
		stp_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// a restart from reset, then plain advances on the reset registers
	task automatic test_reset_state();
		gap_pct = 30;
		send_step(1'b1);
		repeat (3) send_step(1'b0);
		wait_until_drained();
	endtask

	// zero maxima wrap at once; then a small mixed radix runs round to a wrap,
	// with class 2 limit above its zero max so it is clamped
	task automatic test_wrap_and_clamp();
		program_classes(4'd0, 4'd0, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15, 4'd15);
		send_step(1'b0);
		wait_until_drained();
		program_classes(4'd15, 4'd0, 4'd3, 4'd15, 4'd1, 4'd15, 4'd2, 4'd1);
		// 12 populations, so the twelfth advance wraps and one more follows
		repeat (13) send_step(1'b0);
		wait_until_drained();
	endtask

	// counts left above a lowered limit or max must carry on the next advance
	task automatic test_count_above_limit();
		program_classes(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
		repeat (3) send_step(1'b0);
		wait_until_drained();
		apb_write_reg(REG_LIMIT_4, 4'd1);
		send_step(1'b0);
		wait_until_drained();
		apb_write_reg(REG_MAX_3, 4'd0);
		repeat (2) send_step(1'b0);
		send_step(1'b1);
		wait_until_drained();
	endtask

	// full radix: raise each class to 15 in turn up to offset 65535, then wrap
	task automatic test_full_scale_climb();
		gap_pct = 15;
		program_classes(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0);
		send_step(1'b1);
		repeat (15) send_step(1'b0);
		wait_until_drained();
		apb_write_reg(REG_LIMIT_2, 4'd15);
		repeat (15) send_step(1'b0);
		wait_until_drained();
		apb_write_reg(REG_LIMIT_3, 4'd15);
		repeat (15) send_step(1'b0);
		wait_until_drained();
		apb_write_reg(REG_LIMIT_4, 4'd15);
		repeat (16) send_step(1'b0);
		wait_until_drained();
	endtask

	// random register settings in random order, counts carried across phases
	task automatic test_random_settings();
		reg_idx_t order [8];
		reg_idx_t tmp;
		field_t   value;
		int       j;
		for (int i = 0; i < 8; i++)
			order[i] = reg_idx_t'(i);
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			for (int i = 7; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			for (int i = 0; i < 8; i++) begin
				// maxima lean to the extremes, limits lean small so wraps come often
				if (order[i] <= REG_MAX_4) begin
					case ($urandom_range(3))
						0: value = 4'd0;
						1: value = 4'd15;
						default: value = field_t'($urandom_range(15));
					endcase
				end else begin
					case ($urandom_range(3))
						0, 1: value = field_t'($urandom_range(2));
						2: value = 4'd15;
						default: value = field_t'($urandom_range(15));
					endcase
				end
				apb_write_reg(order[i], value);
			end
			repeat (PHASE_WORDS) send_step($urandom_range(15) == 0);
			wait_until_drained();
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_closing_burst();
		gap_pct = 0;
		program_classes(4'd2, 4'd15, 4'd1, 4'd3, 4'd1, 4'd2, 4'd15, 4'd3);
		repeat (CLOSING_WORDS) send_step($urandom_range(15) == 0);
		wait_until_drained();
	endtask

	// result side: random back-pressure bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_if.ready <= 1'b0;
		end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			stall_left <= $urandom_range(13, 0);
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// each accepted result word against the oldest expectation
	always @(posedge clk) begin : check_words
		odo_word_t want;
		field_t    got_counts [4];
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_words.size() == 0) begin
				flag_mismatch("word with nothing pending", res_if.linear_offset, 0);
			end else begin
				want = pending_words.pop_front();
				got_counts[0] = res_if.count_class_1;
				got_counts[1] = res_if.count_class_2;
				got_counts[2] = res_if.count_class_3;
				got_counts[3] = res_if.count_class_4;
				if (res_if.linear_offset !== want.linear_offset)
					flag_mismatch("linear_offset", res_if.linear_offset, want.linear_offset);
				if (res_if.removed_class !== want.removed_class)
					flag_mismatch("removed_class", res_if.removed_class, want.removed_class);
				if (res_if.wrapped !== want.wrapped)
					flag_mismatch("wrapped", res_if.wrapped, want.wrapped);
				if (res_if.last_of_run !== want.last_of_run)
					flag_mismatch("last_of_run", res_if.last_of_run, want.last_of_run);
				for (int c = 0; c < 4; c++)
					if (got_counts[c] !== want.counts[c])
						flag_mismatch($sformatf("count_class_%0d", c + 1), got_counts[c],
							want.counts[c]);
			end
		end
	end

	// watchdog: too long with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (stp_if.valid && stp_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		// reset state of the shadow registers
		for (int c = 0; c < 4; c++) begin
			pop_count[c]   = '0;
			class_max[c]   = RST_MAX;
			class_limit[c] = RST_MAX;
		end
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		stp_if.valid   <= 1'b0;
		stp_if.restart <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_wrap_and_clamp();
		test_count_above_limit();
		test_full_scale_climb();
		test_random_settings();
		test_closing_burst();

		// let any stray word show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- population_odometer_offset_unit.f -----
+incdir+design
design/podo_pkg.sv
design/podo_step_if.sv
design/podo_result_if.sv
design/podo_cfg.sv
design/podo_step.sv
design/podo_emit.sv
design/population_odometer_offset_unit.sv
tb/sv/testbench.sv
